// ----- rtl/core/job_priority_sorter_top_assert.svh -----
// ----------------------------------------------------------------------------
// Job priority sorter assertion macros
// Shorthand for the concurrent checks used inside the sorter top level.
// ----------------------------------------------------------------------------
`ifndef JOB_PRIORITY_SORTER_TOP_ASSERT_SVH
`define JOB_PRIORITY_SORTER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, masked during reset
`define JPS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, masked during reset
`define JPS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/jps_pkg.sv -----
// ----------------------------------------------------------------------------
// Job priority sorter package
// Shared types, constants and the sort key used by the insertion chain.
// ----------------------------------------------------------------------------
package jps_pkg;

  localparam int JPS_MAX_JOBS = 32;

  typedef struct packed {
    logic        ready;
    logic [7:0]  pri;
    logic [31:0] stamp;
    logic [15:0] tag;
  } jps_rec_t;

  typedef struct packed {
    logic insert;
    logic drain;
  } jps_ctl_t;

  typedef enum logic {
    ST_LOAD,
    ST_DRAIN
  } jps_state_t;

  // Larger key stands earlier: ready, then higher priority, then earlier stamp
  function automatic logic [40:0] sort_key(input jps_rec_t r);
    sort_key = {r.ready, r.pri, ~r.stamp};
  endfunction

endpackage

// ----- rtl/core/jps_cell.sv -----
// ----------------------------------------------------------------------------
// Job priority sorter cell
// One slot of the insertion chain: holds a record, yields to a new record that
// sorts strictly ahead of it, passes its record down on insert, up on drain.
// ----------------------------------------------------------------------------
module jps_cell
  import jps_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  jps_ctl_t ctl,
  input  jps_rec_t new_rec,
  input  logic     left_valid,
  input  jps_rec_t left_rec,
  input  logic     left_take,
  input  logic     right_valid,
  input  jps_rec_t right_rec,
  output logic     valid,
  output jps_rec_t rec,
  output logic     take
);

  logic ahead;

  // Strict compare keeps full ties in arrival order
  assign ahead = sort_key(new_rec) > sort_key(rec);
  assign take  = !valid || ahead;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.drain) begin
      valid <= right_valid;
    end else if (ctl.insert && take) begin
      valid <= left_take ? left_valid : 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.drain) begin
      rec <= right_rec;
    end else if (ctl.insert && take) begin
      rec <= left_take ? left_rec : new_rec;
    end
  end

endmodule

// ----- rtl/core/jps_ctrl.sv -----
// ----------------------------------------------------------------------------
// Job priority sorter control
// Load/drain sequencer, handshake control and the per-list overflow flag.
// ----------------------------------------------------------------------------
module jps_ctrl
  import jps_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  logic     last_record,
  input  logic     full,
  input  logic     res_ready,
  input  logic     last_pos,
  output logic     in_ready,
  output logic     res_valid,
  output jps_ctl_t ctl,
  output logic     overflowed
);

  jps_state_t state;
  jps_state_t state_next;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = res_valid && res_ready;

  always_comb begin
    state_next = state;
    case (state)
      ST_LOAD: begin
        if (in_acc && last_record) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (out_acc && last_pos) begin
          state_next = ST_LOAD;
        end
      end
      default: state_next = ST_LOAD;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    res_valid  = 1'b0;
    ctl.insert = 1'b0;
    ctl.drain  = 1'b0;
    case (state)
      ST_LOAD: begin
        in_ready   = 1'b1;
        ctl.insert = in_valid && !full;
      end
      ST_DRAIN: begin
        res_valid = 1'b1;
        ctl.drain = res_ready;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // Set on a dropped record, drop again once the run has gone out
  always_ff @(posedge clk) begin
    if (rst) begin
      overflowed <= 1'b0;
    end else if (in_acc && full) begin
      overflowed <= 1'b1;
    end else if (out_acc && last_pos) begin
      overflowed <= 1'b0;
    end
  end

endmodule

// ----- rtl/core/job_priority_sorter_top.sv -----
// ----------------------------------------------------------------------------
// Job priority sorter top level
// Stable insertion sort of job records over a chain of cells.
// ----------------------------------------------------------------------------
// Records are taken one per cycle while loading: each is compared with every
// cell of the chain in the cycle it arrives and slots into its sorted place,
// the cells behind it moving one place down. Up to MAX_JOBS records are kept;
// further records are dropped and every result of that run carries
// overflowed. Accepting the record with last_record starts the run: from the
// next cycle the head cell is presented as a result and the chain moves up one
// cell per accepted result, with last_out on the final one. Input is held off
// during the run. Order: ready jobs first, then higher priority, then earlier
// submit time; full ties leave in arrival order.
module job_priority_sorter_top
  import jps_pkg::*;
#(
  parameter int MAX_JOBS = JPS_MAX_JOBS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] job_tag,
  input  logic [7:0]  priority_req,
  input  logic [31:0] submit_time,
  input  logic [15:0] done_count,
  input  logic [15:0] error_count,
  input  logic [15:0] total_count,
  input  logic        last_record,
  output logic        res_valid,
  input  logic        res_ready,
  output logic [15:0] out_tag,
  output logic        out_ready,
  output logic        overflowed,
  output logic        last_out
);

`include "job_priority_sorter_top_assert.svh"

  jps_ctl_t    ctl;
  jps_rec_t    new_rec;
  logic [16:0] frame_sum;
  logic        full;

  logic        cell_valid [MAX_JOBS];
  jps_rec_t    cell_rec   [MAX_JOBS];
  logic        cell_take  [MAX_JOBS];

  assign frame_sum       = {1'b0, done_count} + {1'b0, error_count};
  assign new_rec.ready   = (frame_sum == {1'b0, total_count});
  assign new_rec.pri     = priority_req;
  assign new_rec.stamp   = submit_time;
  assign new_rec.tag     = job_tag;

  assign full = cell_valid[MAX_JOBS-1];

  for (genvar i = 0; i < MAX_JOBS; i++) begin : g_cell
    logic     lv;
    jps_rec_t lr;
    logic     lt;
    logic     rv;
    jps_rec_t rr;

    if (i == 0) begin : g_head
      assign lv = 1'b1;
      assign lr = new_rec;
      assign lt = 1'b0;
    end else begin : g_body
      assign lv = cell_valid[i-1];
      assign lr = cell_rec[i-1];
      assign lt = cell_take[i-1];
    end

    if (i == MAX_JOBS - 1) begin : g_tail
      assign rv = 1'b0;
      assign rr = '0;
    end else begin : g_inner
      assign rv = cell_valid[i+1];
      assign rr = cell_rec[i+1];
    end

    jps_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctl         (ctl),
      .new_rec     (new_rec),
      .left_valid  (lv),
      .left_rec    (lr),
      .left_take   (lt),
      .right_valid (rv),
      .right_rec   (rr),
      .valid       (cell_valid[i]),
      .rec         (cell_rec[i]),
      .take        (cell_take[i])
    );
  end

  jps_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .last_record (last_record),
    .full        (full),
    .res_ready   (res_ready),
    .last_pos    (last_out),
    .in_ready    (in_ready),
    .res_valid   (res_valid),
    .ctl         (ctl),
    .overflowed  (overflowed)
  );

  assign out_tag   = cell_rec[0].tag;
  assign out_ready = cell_rec[0].ready;
  assign last_out  = !cell_valid[1];

  `JPS_ASSERT_NOW(a_head_valid, res_valid, cell_valid[0], "result shown from empty head cell")
  `JPS_ASSERT_NOW(a_no_insert_full, ctl.insert, !full && !ctl.drain, "insert into full chain")
  `JPS_ASSERT_NEXT(a_run_starts, in_valid && in_ready && last_record, res_valid,
                   "run did not start after last record")
  `JPS_ASSERT_NEXT(a_run_empties, res_valid && res_ready && last_out,
                   !cell_valid[0] && in_ready, "chain not empty after run")

endmodule
